// ----- design/pid_pkg.sv -----
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants
// Widths, register indexes and sequencer states of the PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int DATA_W  = 32;
    localparam int BOUND_W = 31;
    localparam int INTEG_W = 48;
    localparam int OPND_W  = 33;
    localparam int PROD_W  = 66;
    localparam int ACC_W   = 68;
    localparam int PD_W    = 52;
    localparam int NUM_W   = 52;
    localparam int FRAC_W  = 16;
    localparam int DIVD_W  = NUM_W + FRAC_W;

    typedef enum logic [2:0] {
        REG_TARGET    = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_GAIN_D    = 3'd3,
        REG_INT_BOUND = 3'd4,
        REG_OUT_BOUND = 3'd5,
        REG_ERR_BOUND = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_MUL,
        S_DEC,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ----- design/pid_mul.sv -----
// ----------------------------------------------------------------------------
// pid_mul: shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module pid_mul
    import pid_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [OPND_W-1:0]  i_a,
    input  logic signed [OPND_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ----- design/pid_div.sv -----
// ----------------------------------------------------------------------------
// pid_div: iterative unsigned divider
// Restoring division of (num << 16) by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pid_div
    import pid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DATA_W-1:0]    i_den,
    output logic                 o_done,
    output logic [DIVD_W-1:0]    o_quo
);

    logic                r_busy;
    logic                r_done;
    logic [6:0]          r_cnt;
    logic [DATA_W-1:0]   r_rem;
    logic [DIVD_W-1:0]   r_num;
    logic [DIVD_W-1:0]   r_quo;
    logic [DATA_W:0]     n_trial;
    logic                n_qbit;

    always_comb begin
        n_trial = {r_rem, r_num[DIVD_W-1]};
        n_qbit  = (n_trial >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {i_num, {FRAC_W{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIVD_W-2:0], 1'b0};
            r_rem <= n_qbit ? DATA_W'(n_trial - {1'b0, i_den}) : n_trial[DATA_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], n_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- design/pid_position_antiwindup.sv -----
// ----------------------------------------------------------------------------
// pid_position_antiwindup: positional PID with back-calculation anti-windup
// Signed Q16.16 PID controller with error, integral and output clamps.
// ----------------------------------------------------------------------------
// One request is taken at a time. A normal request passes the error step,
// four products through the shared multiplier and the decision before its
// result is valid. When the output clamps and gain_i is non-zero the integral
// is recomputed by the iterative divider. A clear request answers in the next
// cycle. Configuration is the user's to write while idle; it is not enforced.
module pid_position_antiwindup
    import pid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] measured_value
    input  logic        s_axis_tuser,   // [0] clear_state
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] drive_value
    output logic [1:0]  m_axis_tuser,   // [0] clamped_high, [1] clamped_low
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic signed [INTEG_W-1:0] INT48_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INT48_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    t_state r_state, n_state;

    logic signed [DATA_W-1:0]  r_target, r_gp, r_gi, r_gd;
    logic [BOUND_W-1:0]        r_ib, r_ob, r_eb;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [DATA_W-1:0]  r_prev;
    logic signed [DATA_W-1:0]  r_meas;
    logic signed [DATA_W-1:0]  r_err;
    logic signed [OPND_W-1:0]  r_de;
    logic [2:0]                r_step;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [PD_W-1:0]    r_pd;
    logic                      r_neg;
    logic signed [DATA_W-1:0]  r_drive;
    logic                      r_hi, r_lo;

    logic signed [OPND_W-1:0]  n_a, n_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   n_term;
    logic signed [DATA_W:0]    n_diff;
    logic signed [DATA_W-1:0]  n_err;
    logic signed [ACC_W-1:0]   n_obw;
    logic signed [PD_W:0]      n_it_hi, n_it_lo;
    logic signed [PD_W:0]      n_it;
    logic                      n_clamp_hi, n_clamp_lo;
    logic                      n_div_start;
    logic [NUM_W-1:0]          n_num;
    logic                      w_div_done;
    logic [DIVD_W-1:0]         w_quo;
    logic signed [INTEG_W:0]   n_isum;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [INTEG_W-1:0] n_ibw;
    logic signed [INTEG_W-1:0] n_qsat;
    logic                      w_in_req, w_out_req;

    assign w_in_req  = s_axis_tvalid && s_axis_tready;
    assign w_out_req = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0; r_gp <= '0; r_gi <= '0; r_gd <= '0;
            r_ib <= '0; r_ob <= '0; r_eb <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET:    r_target <= i_cfg_data;
                REG_GAIN_P:    r_gp <= i_cfg_data;
                REG_GAIN_I:    r_gi <= i_cfg_data;
                REG_GAIN_D:    r_gd <= i_cfg_data;
                REG_INT_BOUND: r_ib <= i_cfg_data[BOUND_W-1:0];
                REG_OUT_BOUND: r_ob <= i_cfg_data[BOUND_W-1:0];
                REG_ERR_BOUND: r_eb <= i_cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_diff = {r_target[DATA_W-1], r_target} - {r_meas[DATA_W-1], r_meas};
        if (n_diff > $signed({2'b00, {(DATA_W-1){1'b1}}})) begin
            n_err = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (n_diff < $signed({2'b11, {(DATA_W-1){1'b0}}})) begin
            n_err = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_err = n_diff[DATA_W-1:0];
        end
        if (r_eb != '0) begin
            if (n_err > $signed({1'b0, r_eb})) begin
                n_err = {1'b0, r_eb};
            end else if (n_err < -$signed({1'b0, r_eb})) begin
                n_err = -$signed({1'b0, r_eb});
            end
        end
    end

    always_comb begin
        case (r_step)
            3'd0: begin n_a = OPND_W'(r_gp); n_b = OPND_W'(r_err); end
            3'd1: begin n_a = OPND_W'(r_gd); n_b = r_de; end
            3'd2: begin
                n_a = OPND_W'(r_gi);
                n_b = OPND_W'($signed(r_integ[INTEG_W-1:FRAC_W]));
            end
            default: begin
                n_a = OPND_W'(r_gi);
                n_b = $signed({{(OPND_W-FRAC_W){1'b0}}, r_integ[FRAC_W-1:0]});
            end
        endcase
    end

    pid_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (n_a),
        .i_b    (n_b),
        .o_prod (w_prod)
    );

    always_comb begin
        if (r_step == 3'd3) begin
            n_term = ACC_W'(w_prod);
        end else begin
            n_term = ACC_W'(w_prod >>> FRAC_W);
        end
    end

    always_comb begin
        n_obw      = $signed({{(ACC_W-BOUND_W){1'b0}}, r_ob});
        n_clamp_hi = (r_ob != '0) && (r_acc > n_obw);
        n_clamp_lo = (r_ob != '0) && (r_acc < -n_obw);
        n_it_hi    = $signed({{(PD_W+1-BOUND_W){1'b0}}, r_ob}) - (PD_W+1)'(r_pd);
        n_it_lo    = -$signed({{(PD_W+1-BOUND_W){1'b0}}, r_ob}) - (PD_W+1)'(r_pd);
        if (n_clamp_hi) begin
            n_it = (n_it_hi < 0) ? '0 : n_it_hi;
        end else begin
            n_it = (n_it_lo > 0) ? '0 : n_it_lo;
        end
        n_num       = NUM_W'((n_it < 0) ? -n_it : n_it);
        n_div_start = (r_state == S_DEC) && (n_clamp_hi || n_clamp_lo) && (r_gi != '0);
    end

    pid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_num),
        .i_den   (r_gi[DATA_W-1] ? DATA_W'(-r_gi) : r_gi),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_isum = {r_integ[INTEG_W-1], r_integ} + (INTEG_W+1)'(r_err);
        if (n_isum > $signed({1'b0, INT48_MAX})) begin
            n_integ = INT48_MAX;
        end else if (n_isum < $signed({1'b1, INT48_MIN})) begin
            n_integ = INT48_MIN;
        end else begin
            n_integ = n_isum[INTEG_W-1:0];
        end
        n_ibw = $signed({{(INTEG_W-BOUND_W){1'b0}}, r_ib});
        if (r_ib != '0) begin
            if (n_integ > n_ibw) begin
                n_integ = n_ibw;
            end else if (n_integ < -n_ibw) begin
                n_integ = -n_ibw;
            end
        end
        if (r_neg) begin
            n_qsat = (w_quo >= (DIVD_W'(1) << (INTEG_W-1))) ? INT48_MIN
                                                             : -$signed(w_quo[INTEG_W-1:0]);
        end else begin
            n_qsat = (w_quo > DIVD_W'(INT48_MAX)) ? INT48_MAX : $signed(w_quo[INTEG_W-1:0]);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_req) n_state = s_axis_tuser ? S_OUT : S_ERR;
            S_ERR:  n_state = S_MUL;
            S_MUL:  if (r_step == 3'd4) n_state = S_DEC;
            S_DEC:  n_state = n_div_start ? S_DIV : S_OUT;
            S_DIV:  if (w_div_done) n_state = S_OUT;
            S_OUT:  if (w_out_req) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
        m_axis_tdata  = r_drive;
        m_axis_tuser  = {r_lo, r_hi};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_integ <= '0;
            r_prev  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_in_req && s_axis_tuser) begin
                        r_integ <= '0;
                        r_prev  <= '0;
                    end
                end
                S_ERR: begin
                    r_step <= '0;
                end
                S_MUL: begin
                    r_step <= r_step + 3'd1;
                end
                S_DEC: begin
                    r_prev <= r_err;
                    if (!(n_clamp_hi || n_clamp_lo) && (r_gi != '0)) begin
                        r_integ <= n_integ;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_integ <= n_qsat;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_meas  <= s_axis_tdata;
                r_drive <= '0;
                r_hi    <= 1'b0;
                r_lo    <= 1'b0;
            end
            S_ERR: begin
                r_err <= n_err;
                r_de  <= {n_err[DATA_W-1], n_err} - {r_prev[DATA_W-1], r_prev};
                r_acc <= '0;
                r_pd  <= '0;
            end
            S_MUL: begin
                if (r_step != 3'd0) begin
                    r_acc <= r_acc + n_term;
                    if (r_step <= 3'd2) begin
                        r_pd <= r_pd + PD_W'(n_term);
                    end
                end
            end
            S_DEC: begin
                r_neg <= (n_it < 0) != r_gi[DATA_W-1];
                r_hi  <= n_clamp_hi;
                r_lo  <= n_clamp_lo;
                if (n_clamp_hi) begin
                    r_drive <= {1'b0, r_ob};
                end else if (n_clamp_lo) begin
                    r_drive <= -$signed({1'b0, r_ob});
                end else if (r_acc > $signed(ACC_W'(32'h7fffffff))) begin
                    r_drive <= {1'b0, {(DATA_W-1){1'b1}}};
                end else if (r_acc < -$signed(ACC_W'(33'h080000000))) begin
                    r_drive <= {1'b1, {(DATA_W-1){1'b0}}};
                end else begin
                    r_drive <= r_acc[DATA_W-1:0];
                end
            end
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("both clamp flags set");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_req && s_axis_tuser) |=> (r_integ == '0 && r_prev == '0 && r_drive == '0))
        else $error("clear request left state");

    a_hi_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == {1'b0, r_ob}))
        else $error("high clamp drive mismatch");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while result pending");

endmodule
